@@ rtl/dpd_pkg.sv @@
// ----------------------------------------------------------------------------
// dpd_pkg - shared types and float helpers for the int8 dot-product block
// Job word passed from the accumulator front to the float back end, queue
// sizing, and classification of binary32 special operands.
// ----------------------------------------------------------------------------
package dpd_pkg;

  localparam int JOBQ_DEPTH = 2;
  localparam int JOBQ_AW    = 1;
  localparam int JOBQ_CW    = 2;

  localparam logic [31:0] CANON_NAN = 32'h7FC00000;
  localparam logic [30:0] INF_MAG   = 31'h7F800000;

  // One finished dot product waiting for its epilogue.
  typedef struct packed {
    logic [31:0] acc;
    logic [31:0] wscale;
    logic [31:0] ascale;
    logic [31:0] bias;
  } job_t;

  // Early-out result for special operands.
  typedef struct packed {
    logic        hit;
    logic [31:0] bits;
  } spec_t;

  function automatic logic f_nan(input logic [31:0] x);
    f_nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic f_inf(input logic [31:0] x);
    f_inf = (x[30:0] == INF_MAG);
  endfunction

  function automatic logic f_zero(input logic [31:0] x);
    f_zero = (x[30:0] == 31'd0);
  endfunction

  // a * b, special operands only.
  function automatic spec_t mul_special(input logic [31:0] a, input logic [31:0] b);
    spec_t r;
    logic  sx;
    sx = a[31] ^ b[31];
    r.hit  = 1'b1;
    r.bits = CANON_NAN;
    if (f_nan(a) || f_nan(b) || (f_inf(a) && f_zero(b)) || (f_zero(a) && f_inf(b))) begin
      r.bits = CANON_NAN;
    end else if (f_inf(a) || f_inf(b)) begin
      r.bits = {sx, INF_MAG};
    end else if (f_zero(a) || f_zero(b)) begin
      r.bits = {sx, 31'd0};
    end else begin
      r.hit = 1'b0;
    end
    mul_special = r;
  endfunction

  // a * b + c, special operands only.
  function automatic spec_t fma_special(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c);
    spec_t r;
    logic  sp;
    logic  p_inf;
    logic  p_zero;
    sp     = a[31] ^ b[31];
    p_inf  = f_inf(a) || f_inf(b);
    p_zero = f_zero(a) || f_zero(b);
    r.hit  = 1'b1;
    r.bits = CANON_NAN;
    if (f_nan(a) || f_nan(b) || f_nan(c) || (f_inf(a) && f_zero(b)) ||
        (f_zero(a) && f_inf(b)) || (p_inf && f_inf(c) && (sp != c[31]))) begin
      r.bits = CANON_NAN;
    end else if (p_inf) begin
      r.bits = {sp, INF_MAG};
    end else if (f_inf(c)) begin
      r.bits = c;
    end else if (p_zero) begin
      if (f_zero(c)) begin
        r.bits = (sp == c[31]) ? {sp, 31'd0} : 32'd0;
      end else begin
        r.bits = c;
      end
    end else begin
      r.hit = 1'b0;
    end
    fma_special = r;
  endfunction

endpackage

@@ rtl/dpd_front.sv @@
// ----------------------------------------------------------------------------
// dpd_front - int8 group accumulator
// Adds four int8 products per accepted word into a wrapping 32-bit sum and
// hands a job to the queue on the last group.
// ----------------------------------------------------------------------------
module dpd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [7:0]  weight_0,
  input  logic signed [7:0]  weight_1,
  input  logic signed [7:0]  weight_2,
  input  logic signed [7:0]  weight_3,
  input  logic signed [7:0]  act_0,
  input  logic signed [7:0]  act_1,
  input  logic signed [7:0]  act_2,
  input  logic signed [7:0]  act_3,
  input  logic [31:0]        weight_scale,
  input  logic [31:0]        act_scale,
  input  logic [31:0]        bias_value,
  input  logic               last_group,
  input  logic               q_full,
  output logic               q_wr,
  output dpd_pkg::job_t      q_job
);

  logic [31:0]        acc;
  logic [31:0]        acc_next;
  logic signed [15:0] p0, p1, p2, p3;
  logic signed [17:0] dsum;
  logic               accept;

  assign accept = push && !q_full;
  assign full   = q_full;

  always_comb begin
    p0       = weight_0 * act_0;
    p1       = weight_1 * act_1;
    p2       = weight_2 * act_2;
    p3       = weight_3 * act_3;
    dsum     = 18'(p0) + 18'(p1) + 18'(p2) + 18'(p3);
    acc_next = acc + 32'(dsum);
  end

  assign q_wr         = accept && last_group;
  assign q_job.acc    = acc_next;
  assign q_job.wscale = weight_scale;
  assign q_job.ascale = act_scale;
  assign q_job.bias   = bias_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 32'd0;
    end else if (accept) begin
      acc <= last_group ? 32'd0 : acc_next;
    end
  end

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    (accept && last_group) |=> (acc == 32'd0))
    else $error("accumulator not cleared after last group");

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (push && q_full) |=> $stable(acc))
    else $error("accumulator moved on a blocked word");

  a_job_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    q_wr |-> !q_full)
    else $error("job written into a full queue");

endmodule

@@ rtl/dpd_jobq.sv @@
// ----------------------------------------------------------------------------
// dpd_jobq - short job queue
// Register FIFO between the accumulator front and the float back end.
// ----------------------------------------------------------------------------
module dpd_jobq (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  dpd_pkg::job_t wdata,
  output logic          full,
  input  logic          rd,
  output logic          empty,
  output dpd_pkg::job_t rdata
);

  dpd_pkg::job_t                 mem [dpd_pkg::JOBQ_DEPTH];
  logic [dpd_pkg::JOBQ_AW-1:0]   wptr;
  logic [dpd_pkg::JOBQ_AW-1:0]   rptr;
  logic [dpd_pkg::JOBQ_CW-1:0]   count;
  logic                          do_wr;
  logic                          do_rd;

  assign full  = (count == dpd_pkg::JOBQ_CW'(dpd_pkg::JOBQ_DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= dpd_pkg::JOBQ_CW'(dpd_pkg::JOBQ_DEPTH))
    else $error("job queue count past depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || full) |-> (wptr == rptr))
    else $error("job queue pointers disagree with count");

  a_rd_drains: assert property (@(posedge clk) disable iff (rst)
    (do_rd && !do_wr) |=> (count == $past(count) - 1'b1))
    else $error("job queue read lost");

endmodule

@@ rtl/dpd_back.sv @@
// ----------------------------------------------------------------------------
// dpd_back - binary32 epilogue sequencer
// Converts the sum to float, multiplies by the weight scale, then a fused
// multiply-add with the activation scale and bias, over a shared normalizer.
// ----------------------------------------------------------------------------
module dpd_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  dpd_pkg::job_t q_job,
  output logic          q_rd,
  output logic          empty,
  input  logic          pop,
  output logic [31:0]   result_bits
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_NORM  = 4'd1;
  localparam logic [3:0] S_DEN   = 4'd2;
  localparam logic [3:0] S_RND   = 4'd3;
  localparam logic [3:0] S_UNPK  = 4'd4;
  localparam logic [3:0] S_OPN   = 4'd5;
  localparam logic [3:0] S_PROD  = 4'd6;
  localparam logic [3:0] S_ALIGN = 4'd7;
  localparam logic [3:0] S_ADD   = 4'd8;
  localparam logic [3:0] S_FIX   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  localparam logic [1:0] PH_CONV = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_FMA  = 2'd2;

  localparam logic [2:0] NORM_LAST = 3'd6;
  localparam logic [2:0] OPN_LAST  = 3'd4;

  function automatic logic [23:0] unpk_m(input logic [31:0] x);
    unpk_m = (x[30:23] == 8'd0) ? {1'b0, x[22:0]} : {1'b1, x[22:0]};
  endfunction

  function automatic logic signed [11:0] unpk_e(input logic [31:0] x);
    unpk_e = (x[30:23] == 8'd0) ? -12'sd149 : ($signed({4'b0, x[30:23]}) - 12'sd150);
  endfunction

  function automatic logic [79:0] rsh_jam(input logic [79:0] v, input logic [6:0] a);
    logic lost;
    lost    = |(v & ~({80{1'b1}} << a));
    rsh_jam = (v >> a) | {79'd0, lost};
  endfunction

  function automatic logic [6:0] clip7(input logic signed [11:0] v);
    clip7 = (v > 12'sd127) ? 7'd127 : v[6:0];
  endfunction

  logic [3:0]         state;
  logic [1:0]         phase;
  logic [2:0]         stage;

  logic [31:0]        wsc, asc, bia, fa, res;
  logic [23:0]        om [3];
  logic signed [11:0] oe [3];
  logic               os [3];

  logic [47:0]        pm;
  logic signed [11:0] pe;
  logic               psn;

  logic [79:0]        nm;
  logic signed [11:0] ne;
  logic signed [11:0] nbx;
  logic               nst, nsg;

  logic [79:0]        ax, ay;
  logic               asx, asy, asub;
  logic signed [11:0] af;
  logic [80:0]        sm;

  // combinational helpers
  logic [31:0]        opb;
  dpd_pkg::spec_t     spec;
  logic [6:0]         nk;
  logic               n_topz;
  logic [4:0]         ok;
  logic               o_topz [3];
  logic signed [11:0] den_bx;
  logic [6:0]         den_amt;
  logic [23:0]        r_mant;
  logic               r_inc;
  logic [24:0]        r_sum;
  logic [31:0]        r_val;
  logic [31:0]        rnd;
  logic signed [11:0] al_d;
  logic signed [11:0] al_sh;
  logic               al_cbig;
  logic [79:0]        al_x, al_y;
  logic signed [11:0] al_f;
  logic [79:0]        fx_mag;

  assign q_rd        = (state == S_IDLE) && !q_empty;
  assign empty       = (state != S_OUT);
  assign result_bits = res;

  always_comb begin
    opb  = (phase == PH_MUL) ? wsc : asc;
    spec = (phase == PH_MUL) ? dpd_pkg::mul_special(fa, wsc)
                             : dpd_pkg::fma_special(fa, asc, bia);

    // normalizer: shift steps of 64 down to 1
    nk     = 7'd64 >> stage;
    n_topz = ((nm >> (7'd80 - nk)) == 80'd0);

    // operand normalizer: shift steps of 16 down to 1
    ok = 5'd16 >> stage;
    for (int i = 0; i < 3; i++) begin
      o_topz[i] = ((om[i] >> (5'd24 - ok)) == 24'd0);
    end

    // leading one sits at bit 79: biased exponent is ne + 79 + 127
    den_bx  = ne + 12'sd206;
    den_amt = clip7(12'sd1 - den_bx);

    // round to nearest even on bits [79:56]
    r_mant = nm[79:56];
    r_inc  = nm[55] && ((|nm[54:0]) || nst || r_mant[0]);
    r_sum  = {1'b0, r_mant} + {24'd0, r_inc};
    r_val  = {1'b0, 8'(nbx - 12'sd1), 23'd0} + {7'd0, r_sum};
    rnd    = (nbx >= 12'sd255) ? {nsg, dpd_pkg::INF_MAG} : {nsg, r_val[30:0]};

    // alignment of product (48b) and addend (24b) in an 80-bit frame
    al_d    = oe[2] - pe - 12'sd24;
    al_cbig = (om[2] != 24'd0) && (al_d >= 12'sd0);
    if (al_cbig) begin
      al_x  = 80'(om[2]) << 55;
      al_sh = 12'sd31 - al_d;
      al_y  = (al_sh >= 12'sd0) ? (80'(pm) << al_sh[4:0])
                                : rsh_jam(80'(pm), clip7(-al_sh));
      al_f  = oe[2] - 12'sd55;
    end else begin
      al_x  = 80'(pm) << 31;
      al_sh = 12'sd55 + al_d;
      al_y  = (al_sh >= 12'sd0) ? (80'(om[2]) << al_sh[5:0])
                                : rsh_jam(80'(om[2]), clip7(-al_sh));
      al_f  = pe - 12'sd31;
    end

    fx_mag = sm[80] ? (~sm[79:0] + 80'd1) : sm[79:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_CONV;
      stage <= 3'd0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            wsc   <= q_job.wscale;
            asc   <= q_job.ascale;
            bia   <= q_job.bias;
            stage <= 3'd0;
            if (q_job.acc == 32'd0) begin
              fa    <= 32'd0;
              phase <= PH_MUL;
              state <= S_UNPK;
            end else begin
              nsg   <= q_job.acc[31];
              nm    <= {48'd0, q_job.acc[31] ? (~q_job.acc + 32'd1) : q_job.acc};
              ne    <= 12'sd0;
              nst   <= 1'b0;
              phase <= PH_CONV;
              state <= S_NORM;
            end
          end
        end
        S_NORM: begin
          if (n_topz) begin
            nm <= nm << nk;
            ne <= ne - $signed({5'd0, nk});
          end
          stage <= stage + 3'd1;
          if (stage == NORM_LAST) begin
            state <= S_DEN;
          end
        end
        S_DEN: begin
          if (den_bx < 12'sd1) begin
            nm  <= rsh_jam(nm, den_amt);
            nbx <= 12'sd1;
          end else begin
            nbx <= den_bx;
          end
          state <= S_RND;
        end
        S_RND: begin
          case (phase)
            PH_CONV: begin
              fa    <= rnd;
              phase <= PH_MUL;
              state <= S_UNPK;
            end
            PH_MUL: begin
              fa    <= rnd;
              phase <= PH_FMA;
              state <= S_UNPK;
            end
            default: begin
              res   <= rnd;
              state <= S_OUT;
            end
          endcase
        end
        S_UNPK: begin
          stage <= 3'd0;
          if (spec.hit) begin
            if (phase == PH_MUL) begin
              fa    <= spec.bits;
              phase <= PH_FMA;
            end else begin
              res   <= spec.bits;
              state <= S_OUT;
            end
          end else begin
            om[0] <= unpk_m(fa);
            oe[0] <= unpk_e(fa);
            os[0] <= fa[31];
            om[1] <= unpk_m(opb);
            oe[1] <= unpk_e(opb);
            os[1] <= opb[31];
            om[2] <= unpk_m(bia);
            oe[2] <= unpk_e(bia);
            os[2] <= bia[31];
            state <= S_OPN;
          end
        end
        S_OPN: begin
          for (int i = 0; i < 3; i++) begin
            if (o_topz[i]) begin
              om[i] <= om[i] << ok;
              oe[i] <= oe[i] - $signed({7'd0, ok});
            end
          end
          stage <= stage + 3'd1;
          if (stage == OPN_LAST) begin
            state <= S_PROD;
          end
        end
        S_PROD: begin
          stage <= 3'd0;
          if (phase == PH_MUL) begin
            nm    <= {32'd0, 48'(om[0]) * 48'(om[1])};
            ne    <= oe[0] + oe[1];
            nsg   <= os[0] ^ os[1];
            nst   <= 1'b0;
            state <= S_NORM;
          end else begin
            pm    <= om[0] * om[1];
            pe    <= oe[0] + oe[1];
            psn   <= os[0] ^ os[1];
            state <= S_ALIGN;
          end
        end
        S_ALIGN: begin
          ax    <= al_x;
          ay    <= al_y;
          af    <= al_f;
          asx   <= al_cbig ? os[2] : psn;
          asy   <= al_cbig ? psn : os[2];
          asub  <= os[2] ^ psn;
          state <= S_ADD;
        end
        S_ADD: begin
          sm    <= asub ? ({1'b0, ax} - {1'b0, ay}) : ({1'b0, ax} + {1'b0, ay});
          state <= S_FIX;
        end
        S_FIX: begin
          stage <= 3'd0;
          if (sm == 81'd0) begin
            res   <= 32'd0;          // exact cancellation gives +0
            state <= S_OUT;
          end else begin
            nm    <= fx_mag;
            nsg   <= sm[80] ? asy : asx;
            ne    <= af;
            nst   <= 1'b0;
            state <= S_NORM;
          end
        end
        S_OUT: begin
          if (pop) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_idle_is_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> empty)
    else $error("result shown while idle");

  a_pop_frees: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop) |=> (empty && state == S_IDLE))
    else $error("result not retired on pop");

  a_take_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_rd |-> (state == S_IDLE && !q_empty))
    else $error("job taken while busy");

endmodule

@@ rtl/int8_dot_product_dequant.sv @@
// ----------------------------------------------------------------------------
// int8_dot_product_dequant - int8 dot product with binary32 dequant epilogue
// Streams groups of four int8 weight/activation pairs into a wrapping sum and
// emits fma(float(sum) * weight_scale, act_scale, bias) per dot product.
// ----------------------------------------------------------------------------
// Usage:
//  - Input side is a queue write port: a word is taken at a clock edge with
//    push high and full low. Each word adds four int8 products to a 32-bit
//    wrapping sum; the scales and bias are only looked at on the word with
//    last_group set, which closes the dot product.
//  - Result side is a queue read port: while empty is low, result_bits holds
//    the oldest result; it retires on a clock edge with pop high.
//  - Throughput: one group word per cycle while full is low. Full rises only when the
//    two-entry job queue is full, i.e. several closed dot products are
//    waiting on the float epilogue. The epilogue works on one dot product
//    at a time and finishes sooner on special operands, so short dot products back up.
//  - Epilogue: a sequencer around one shared 80-bit normalizer (7 shift
//    steps) and a 24x24 multiplier; with the epilogue idle, a job runs
//    conversion, multiply and fused multiply-add before empty drops, with
//    steps skipped when an operand is special.
//  - A result not popped stalls the epilogue; the accumulator keeps taking
//    words until the job queue fills.
//  - Reset (rst, synchronous) clears the sum, empties the queue and drops
//    any result in flight.
// ----------------------------------------------------------------------------
module int8_dot_product_dequant (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [7:0]  weight_0,
  input  logic signed [7:0]  weight_1,
  input  logic signed [7:0]  weight_2,
  input  logic signed [7:0]  weight_3,
  input  logic signed [7:0]  act_0,
  input  logic signed [7:0]  act_1,
  input  logic signed [7:0]  act_2,
  input  logic signed [7:0]  act_3,
  input  logic [31:0]        weight_scale,
  input  logic [31:0]        act_scale,
  input  logic [31:0]        bias_value,
  input  logic               last_group,
  output logic               empty,
  input  logic               pop,
  output logic [31:0]        result_bits
);

  // front -> queue
  logic          q_wr;
  logic          q_full;
  dpd_pkg::job_t q_wjob;

  // queue -> back
  logic          q_rd;
  logic          q_empty;
  dpd_pkg::job_t q_rjob;

  // accumulator: one group word per cycle while the job queue is not full
  dpd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .weight_0     (weight_0),
    .weight_1     (weight_1),
    .weight_2     (weight_2),
    .weight_3     (weight_3),
    .act_0        (act_0),
    .act_1        (act_1),
    .act_2        (act_2),
    .act_3        (act_3),
    .weight_scale (weight_scale),
    .act_scale    (act_scale),
    .bias_value   (bias_value),
    .last_group   (last_group),
    .q_full       (q_full),
    .q_wr         (q_wr),
    .q_job        (q_wjob)
  );

  // closed dot products waiting for the epilogue
  dpd_jobq u_jobq (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wjob),
    .full  (q_full),
    .rd    (q_rd),
    .empty (q_empty),
    .rdata (q_rjob)
  );

  // float epilogue and result register
  dpd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_job       (q_rjob),
    .q_rd        (q_rd),
    .empty       (empty),
    .pop         (pop),
    .result_bits (result_bits)
  );

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - int8 dot product with binary32 dequant epilogue
// Streams group words through the queue-style ports, predicts each dot
// product result with exact wide-integer float arithmetic, and checks every
// popped result word against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [31:0] F_ONE  = 32'h3F800000;
  localparam logic [31:0] F_HALF = 32'h3F000000;
  localparam logic [31:0] F_TWO  = 32'h40000000;
  localparam logic [31:0] F_MAX  = 32'h7F7FFFFF;
  localparam logic [31:0] F_PINF = 32'h7F800000;
  localparam logic [31:0] F_NINF = 32'hFF800000;
  localparam logic [31:0] F_NEG0 = 32'h80000000;
  localparam logic [31:0] F_QNAN = 32'h7FC00000;

  // wide enough to hold any binary32 product or sum exactly after alignment
  typedef logic [511:0] wide_t;

  // one row of the directed table
  typedef struct {
    logic [31:0] wts;
    logic [31:0] acts;
    logic [31:0] wscale;
    logic [31:0] ascale;
    logic [31:0] bias;
    logic        last;
    int          reps;
    logic        typed;
    logic [31:0] typed_val;
  } group_row_t;

  logic               clk;
  logic               rst;
  logic               push;
  logic               full;
  logic signed [7:0]  weight_0, weight_1, weight_2, weight_3;
  logic signed [7:0]  act_0, act_1, act_2, act_3;
  logic [31:0]        weight_scale;
  logic [31:0]        act_scale;
  logic [31:0]        bias_value;
  logic               last_group;
  logic               empty;
  logic               pop;
  logic [31:0]        result_bits;

  // predictor state: running wrapped int32 sum of products
  logic [31:0]        dot_sum;
  logic [31:0]        pending_results[$];
  group_row_t         rows[$];
  int                 errors;
  logic               steady;      // no idling on either side
  logic               hold_req;    // sender asks receiver for a long hold-off
  logic               hold_done;
  int                 hold_left;

  int8_dot_product_dequant dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .weight_0(weight_0), .weight_1(weight_1), .weight_2(weight_2), .weight_3(weight_3),
    .act_0(act_0), .act_1(act_1), .act_2(act_2), .act_3(act_3),
    .weight_scale(weight_scale), .act_scale(act_scale), .bias_value(bias_value),
    .last_group(last_group), .empty(empty), .pop(pop), .result_bits(result_bits)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- float math

  function automatic logic f32_is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 0);
  endfunction

  function automatic logic f32_is_inf(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 0);
  endfunction

  function automatic logic f32_is_zero(input logic [31:0] x);
    return x[30:0] == 0;
  endfunction

  // value = m * 2^e
  function automatic void f32_split(input logic [31:0] x, output wide_t m, output int e);
    if (x[30:23] == 0) begin
      m = wide_t'(x[22:0]);
      e = -149;
    end else begin
      m = wide_t'({1'b1, x[22:0]});
      e = int'(x[30:23]) - 150;
    end
  endfunction

  // Round sign/magnitude m * 2^e to binary32, nearest even; handles
  // subnormals and overflow to infinity. Zero keeps the given sign.
  function automatic logic [31:0] f32_round(input logic s, input wide_t m, input int e);
    int    msb, lsb, sh, bexp;
    wide_t mant, rem, half;
    if (m == 0) return {s, 31'd0};
    msb = 0;
    for (int i = 0; i < 512; i++) if (m[i]) msb = i;
    lsb = (msb + e < -126) ? -149 : msb + e - 23;
    sh = lsb - e;
    if (sh <= 0) begin
      mant = m << (-sh);
    end else begin
      mant = m >> sh;
      rem  = m & ((wide_t'(1) << sh) - 1);
      half = wide_t'(1) << (sh - 1);
      if (rem > half || (rem == half && mant[0])) mant = mant + 1;
    end
    if (mant[24]) begin
      mant = mant >> 1;
      lsb++;
    end
    bexp = mant[23] ? lsb + 150 : 0;
    if (bexp >= 255) return {s, 8'hFF, 23'd0};
    return {s, bexp[7:0], mant[22:0]};
  endfunction

  function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
    wide_t ma, mb;
    int    ea, eb;
    logic  s;
    s = a[31] ^ b[31];
    if (f32_is_nan(a) || f32_is_nan(b) || (f32_is_inf(a) && f32_is_zero(b)) ||
        (f32_is_zero(a) && f32_is_inf(b))) return F_QNAN;
    if (f32_is_inf(a) || f32_is_inf(b)) return {s, F_PINF[30:0]};
    if (f32_is_zero(a) || f32_is_zero(b)) return {s, 31'd0};
    f32_split(a, ma, ea);
    f32_split(b, mb, eb);
    return f32_round(s, ma * mb, ea + eb);
  endfunction

  // a * b + c with a single rounding
  function automatic logic [31:0] f32_fma(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c);
    wide_t ma, mb, mc, mp, xp, xc, mag;
    int    ea, eb, ec, ep, base;
    logic  sp, p_inf, s;
    sp    = a[31] ^ b[31];
    p_inf = f32_is_inf(a) || f32_is_inf(b);
    if (f32_is_nan(a) || f32_is_nan(b) || f32_is_nan(c)) return F_QNAN;
    if ((f32_is_inf(a) && f32_is_zero(b)) || (f32_is_zero(a) && f32_is_inf(b))) return F_QNAN;
    if (p_inf && f32_is_inf(c) && sp != c[31]) return F_QNAN;
    if (p_inf) return {sp, F_PINF[30:0]};
    if (f32_is_inf(c)) return c;
    f32_split(a, ma, ea);
    f32_split(b, mb, eb);
    f32_split(c, mc, ec);
    mp = ma * mb;
    ep = ea + eb;
    // exact zero + exact zero: sign survives only if both agree
    if (mp == 0 && mc == 0) return (sp == c[31]) ? {sp, 31'd0} : 32'd0;
    base = (ep < ec) ? ep : ec;
    xp = mp << (ep - base);
    xc = mc << (ec - base);
    if (sp == c[31]) begin
      mag = xp + xc;
      s   = sp;
    end else if (xp >= xc) begin
      mag = xp - xc;
      s   = sp;
    end else begin
      mag = xc - xp;
      s   = c[31];
    end
    if (mag == 0) return 32'd0;  // cancellation gives +0 under nearest even
    return f32_round(s, mag, base);
  endfunction

  // Fold one accepted word into the sum; on the closing word return the
  // dequantized result and clear the sum.
  function automatic logic predict_group(input logic [31:0] wts, input logic [31:0] acts,
                                         input logic [31:0] ws, input logic [31:0] as_bits,
                                         input logic [31:0] bias, input logic last,
                                         output logic [31:0] res);
    logic signed [15:0] prod;
    logic [31:0]        mag, sum_f, scaled;
    for (int i = 0; i < 4; i++) begin
      prod    = $signed(wts[8*i +: 8]) * $signed(acts[8*i +: 8]);
      dot_sum = dot_sum + {{16{prod[15]}}, prod};
    end
    res = 32'd0;
    if (!last) return 1'b0;
    mag    = dot_sum[31] ? -dot_sum : dot_sum;
    sum_f  = f32_round(dot_sum[31], wide_t'(mag), 0);
    scaled = f32_mul(sum_f, ws);
    res    = f32_fma(scaled, as_bits, bias);
    dot_sum = 32'd0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h80;
      1:       return 8'h7F;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] rand_f32();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return {r[31], 8'($urandom_range(110, 140)), r[22:0]};
      4, 5:       return r;
      6: begin
        case ($urandom_range(0, 5))
          0:       return 32'd0;
          1:       return F_NEG0;
          2:       return F_PINF;
          3:       return F_NINF;
          4:       return F_QNAN;
          default: return {r[31], 8'hFF, 1'b1, r[21:0]};
        endcase
      end
      7:       return {r[31], 8'd0, r[22:0]};
      8:       return {r[31], 8'($urandom_range(250, 254)), r[22:0]};
      default: return {r[31], 8'($urandom_range(1, 5)), r[22:0]};
    endcase
  endfunction

  task automatic add_row(input logic [31:0] wts, input logic [31:0] acts,
                         input logic [31:0] ws, input logic [31:0] as_bits,
                         input logic [31:0] bias, input logic last, input int reps,
                         input logic typed, input logic [31:0] typed_val);
    group_row_t r;
    r = '{wts, acts, ws, as_bits, bias, last, reps, typed, typed_val};
    rows.push_back(r);
  endtask

  // Offer one word until taken, then record what it should produce.
  task automatic send_word(input logic [31:0] wts, input logic [31:0] acts,
                           input logic [31:0] ws, input logic [31:0] as_bits,
                           input logic [31:0] bias, input logic last,
                           input logic typed, input logic [31:0] typed_val);
    logic [31:0] res;
    while (!steady && $urandom_range(0, 99) < 32) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push         <= 1'b1;
    weight_0     <= wts[7:0];
    weight_1     <= wts[15:8];
    weight_2     <= wts[23:16];
    weight_3     <= wts[31:24];
    act_0        <= acts[7:0];
    act_1        <= acts[15:8];
    act_2        <= acts[23:16];
    act_3        <= acts[31:24];
    weight_scale <= ws;
    act_scale    <= as_bits;
    bias_value   <= bias;
    last_group   <= last;
    do @(posedge clk); while (full);
    if (predict_group(wts, acts, ws, as_bits, bias, last, res))
      pending_results.push_back(typed ? typed_val : res);
  endtask

  initial begin
    logic [31:0] w, a;
    rst = 1'b1;
    push = 1'b0;
    {weight_0, weight_1, weight_2, weight_3} = '0;
    {act_0, act_1, act_2, act_3} = '0;
    weight_scale = '0;
    act_scale = '0;
    bias_value = '0;
    last_group = 1'b0;
    dot_sum = '0;
    errors = 0;
    steady = 1'b0;
    hold_req = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed table. Bytes are packed lane 3..0.
    // empty sum right after reset gives +0
    add_row(32'h0, 32'h0, F_ONE, F_ONE, 32'h0, 1'b1, 1, 1'b1, 32'h00000000);
    // most positive group: 4 * (-128 * -128) = 65536
    add_row(32'h80808080, 32'h80808080, F_ONE, F_ONE, 32'h0, 1'b1, 1, 1'b1, 32'h47800000);
    // most negative group: 4 * (127 * -128) = -65024
    add_row(32'h7F7F7F7F, 32'h80808080, F_ONE, F_ONE, 32'h0, 1'b1, 1, 1'b1, 32'hC77E0000);
    // open group, scales are junk and must be ignored
    add_row(32'h04030201, 32'hF807FA05, 32'hFFFFFFFF, F_PINF, F_QNAN, 1'b0, 1, 1'b0, 32'h0);
    add_row(32'hFE03FF02, 32'h7F80017F, 32'h3DCCCCCD, 32'h40490FDB, 32'hBF800000,
            1'b1, 1, 1'b0, 32'h0);
    // NaN payload in weight scale collapses to canonical NaN
    add_row(32'h01010101, 32'h01010101, 32'h7FC00001, F_ONE, 32'h0, 1'b1, 1, 1'b1, F_QNAN);
    // zero sum times infinity
    add_row(32'h0, 32'h0, F_PINF, F_ONE, 32'h0, 1'b1, 1, 1'b1, F_QNAN);
    // infinite product against infinite bias of opposite sign
    add_row(32'h00000001, 32'h00000001, F_PINF, F_NINF, F_PINF, 1'b1, 1, 1'b1, F_QNAN);
    // bias alone
    add_row(32'h0, 32'h0, F_ONE, F_ONE, F_ONE, 1'b1, 1, 1'b1, F_ONE);
    // signed zeros: -0 + -0 stays negative, -0 + +0 is +0
    add_row(32'h000000FF, 32'h00000001, F_ONE, 32'h0, F_NEG0, 1'b1, 1, 1'b1, F_NEG0);
    add_row(32'h000000FF, 32'h00000001, F_ONE, 32'h0, 32'h0, 1'b1, 1, 1'b1, 32'h0);
    // half of the smallest subnormal ties to even zero
    add_row(32'h00000001, 32'h00000001, 32'h00000001, F_HALF, 32'h0, 1'b1, 1, 1'b1, 32'h0);
    add_row(32'h00000003, 32'h00000001, 32'h00000001, F_HALF, 32'h0, 1'b1, 1, 1'b0, 32'h0);
    // overflow to infinity, in the multiply and in the add
    add_row(32'h00000001, 32'h00000001, F_MAX, F_TWO, 32'h0, 1'b1, 1, 1'b1, F_PINF);
    add_row(32'h00000001, 32'h00000001, F_MAX, F_ONE, F_MAX, 1'b1, 1, 1'b1, F_PINF);
    // infinite bias wins over a finite product; NaN bias gives canonical NaN
    add_row(32'h05050505, 32'h05050505, F_ONE, F_ONE, F_NINF, 1'b1, 1, 1'b1, F_NINF);
    add_row(32'h05050505, 32'h05050505, F_ONE, F_ONE, 32'hFFC12345, 1'b1, 1, 1'b1, F_QNAN);
    // exact cancellation gives +0
    add_row(32'h00000001, 32'h00000001, F_ONE, F_ONE, 32'hBF800000, 1'b1, 1, 1'b1, 32'h0);
    // 2^24 + 1 does not fit in binary32: integer rounding of the sum
    add_row(32'h80808080, 32'h80808080, 32'h0, 32'h0, 32'h0, 1'b0, 256, 1'b0, 32'h0);
    add_row(32'h00000001, 32'h00000001, 32'h3F123456, 32'h3F654321, 32'h0,
            1'b1, 1, 1'b0, 32'h0);

    foreach (rows[i])
      repeat (rows[i].reps)
        send_word(rows[i].wts, rows[i].acts, rows[i].wscale, rows[i].ascale, rows[i].bias,
                  rows[i].last, rows[i].typed, rows[i].typed_val);

    // Random part: dot products of random length, closed by last_group.
    for (int n = 0; n < 175; n++) begin
      if (n == 30) begin
        hold_req = 1'b1;   // receiver stalls, sender keeps pushing
        steady   = 1'b1;
      end
      if (n == 70) steady = 1'b0;
      if (n == 100) begin
        // drain: sender waits until every result is out
        push <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      if (n == 115) steady = 1'b1;
      if (n == 165) steady = 1'b0;
      for (int k = 0; k < 4; k++) begin
        w[8*k +: 8] = rand_byte();
        a[8*k +: 8] = rand_byte();
      end
      send_word(w, a, rand_f32(), rand_f32(), ($urandom_range(0, 4) == 0) ? 32'h0 : rand_f32(),
                $urandom_range(0, 3) == 0, 1'b0, 32'h0);
    end
    push <= 1'b0;
    @(posedge clk);

    while (pending_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- results

  initial begin
    logic [31:0] want;
    pop = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      // pop/empty/result_bits read here still hold their pre-edge values
      if (!rst && pop && !empty) begin
        if (pending_results.size() == 0) begin
          $error("result_bits unexpected word: actual %h", result_bits);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (result_bits !== want) begin
            $error("result_bits mismatch: expected %h, actual %h", want, result_bits);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 400;
        pop <= 1'b0;
      end else begin
        pop <= steady || ($urandom_range(0, 99) >= 32);
      end
    end
  end

endmodule

@@ int8_dot_product_dequant.f @@
rtl/dpd_pkg.sv
rtl/dpd_front.sv
rtl/dpd_jobq.sv
rtl/dpd_back.sv
rtl/int8_dot_product_dequant.sv
bench/testbench.sv
